// ===== hw/rtl/sfp_pkg.sv =====
// Package with the shared constants, types and helper function of the scaled 2bpp packer.
`default_nettype none

package sfp_pkg;

   localparam int SRC_WIDTH  = 320;
   localparam int SRC_HEIGHT = 256;
   localparam int MAX_WORDS  = 19200;
   localparam int SRC_SIZE   = SRC_WIDTH * SRC_HEIGHT;
   localparam int ADDR_W     = $clog2(SRC_SIZE);
   localparam int FRAME_CAP  = (MAX_WORDS < 32768) ? MAX_WORDS : 32768;

   localparam int PIX_W        = 2;
   localparam int PIXEL_ADDR_W = 17;
   localparam int POS_W        = 15;
   localparam int DATA_W       = 16;
   localparam int TOTAL_W      = 16;
   localparam int STEP_W       = 18;
   localparam int FRAC_W       = 16;
   localparam int X_W          = 9;
   localparam int Y_W          = 8;
   localparam int SLOT_W       = 3;

   localparam int X_MAX   = 2 ** X_W - 1;
   localparam int Y_MAX   = 2 ** Y_W - 1;
   localparam int ROW_MAX = Y_MAX + ((Y_MAX * (2 ** STEP_W - 1)) >> FRAC_W);
   localparam int COL_MAX = X_MAX + ((X_MAX * (2 ** STEP_W - 1)) >> FRAC_W);
   localparam int ROW_W   = $clog2(ROW_MAX + 1);
   localparam int COL_W   = $clog2(COL_MAX + 1);
   localparam int LIN_MAX = ROW_MAX * SRC_WIDTH + COL_MAX;
   localparam int LIN_W   = $clog2(LIN_MAX + 1);
   localparam int RED_MAX = (LIN_MAX > 2 ** PIXEL_ADDR_W - 1) ? LIN_MAX : 2 ** PIXEL_ADDR_W - 1;
   localparam int RED_W   = $clog2(RED_MAX + 1);
   localparam int MOD_STEPS = $clog2(RED_MAX / SRC_SIZE + 1);

   localparam int NUM_REGS   = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = $clog2(NUM_REGS * 4);
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_PACK_FORMAT  = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_X_STEP       = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] REG_Y_STEP       = REG_IDX_W'(2);
   localparam logic [REG_IDX_W-1:0] REG_DEST_WIDTH   = REG_IDX_W'(3);
   localparam logic [REG_IDX_W-1:0] REG_DEST_HEIGHT  = REG_IDX_W'(4);
   localparam logic [REG_IDX_W-1:0] REG_SRC_X_OFFSET = REG_IDX_W'(5);
   localparam logic [REG_IDX_W-1:0] REG_SRC_Y_OFFSET = REG_IDX_W'(6);

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EMIT  = 1'b1;

   localparam logic [SLOT_W-1:0] LAST_SLOT_BYTE   = SLOT_W'(3);
   localparam logic [SLOT_W-1:0] LAST_SLOT_PLANES = SLOT_W'(7);

   typedef enum logic [1:0] {
      FMT_HORIZ  = 2'd0,
      FMT_VERT   = 2'd1,
      FMT_PLANES = 2'd2
   } fmt_type;

   typedef struct packed {
      logic                    func;
      logic [PIXEL_ADDR_W-1:0] pixel_address;
      logic [PIX_W-1:0]        pixel_value;
   } req_word_type;

   typedef struct packed {
      logic [POS_W-1:0]  word_address;
      logic [DATA_W-1:0] word_data;
      logic [DATA_W-1:0] slot_mask;
      logic              frame_last;
   } rsp_word_type;

   typedef struct packed {
      fmt_type            fmt;
      logic [X_W-1:0]     width;
      logic [Y_W-1:0]     height;
      logic [STEP_W-1:0]  x_step;
      logic [STEP_W-1:0]  y_step;
      logic [X_W-1:0]     x_off;
      logic [Y_W-1:0]     y_off;
      logic [X_W-1:0]     divisor;
      logic [TOTAL_W-1:0] total;
   } cfg_view_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  wdata;
   } ram_req_type;

   function automatic logic [ADDR_W-1:0] src_reduce(input logic [RED_W-1:0] value);
      logic [RED_W-1:0] rest;
      rest = value;
      for (int j = MOD_STEPS - 1; j >= 0; j--) begin
         if (rest >= RED_W'(SRC_SIZE * (2 ** j))) begin
            rest = rest - RED_W'(SRC_SIZE * (2 ** j));
         end
      end
      return rest[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sfp_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module sfp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sfp_regs.sv =====
// Configuration register file with its APB-style port and the derived frame geometry.
`default_nettype none

module sfp_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sfp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [sfp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [sfp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output sfp_pkg::cfg_view_type            cfg,
   output logic                             cfg_write
);

   import sfp_pkg::*;

   logic [1:0]           fmt_raw_ff;
   logic [STEP_W-1:0]    x_step_ff;
   logic [STEP_W-1:0]    y_step_ff;
   logic [X_W-1:0]       width_ff;
   logic [Y_W-1:0]       height_ff;
   logic [X_W-1:0]       x_off_ff;
   logic [Y_W-1:0]       y_off_ff;
   cfg_view_type         view_ff;
   cfg_view_type         view_in;

   logic [REG_IDX_W-1:0] reg_idx;
   logic [X_W-1:0]       w1;
   logic [Y_W-1:0]       h1;
   logic [X_W:0]         w_sum;
   logic [Y_W:0]         h_sum4;
   logic [Y_W:0]         h_sum8;
   logic [X_W-2:0]       per_row;
   logic [Y_W-2:0]       rows4;
   logic [Y_W-3:0]       rows8;
   logic [TOTAL_W-1:0]   total_raw;

   assign reg_idx   = paddr[CSR_ADDR_W-1:2];
   assign cfg_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_raw_ff <= 2'd0;
         x_step_ff  <= STEP_W'(65536);
         y_step_ff  <= STEP_W'(65536);
         width_ff   <= X_W'(160);
         height_ff  <= Y_W'(128);
         x_off_ff   <= '0;
         y_off_ff   <= '0;
      end else if (cfg_write) begin
         unique case (reg_idx)
            REG_PACK_FORMAT:  fmt_raw_ff <= pwdata[1:0];
            REG_X_STEP:       x_step_ff  <= pwdata[STEP_W-1:0];
            REG_Y_STEP:       y_step_ff  <= pwdata[STEP_W-1:0];
            REG_DEST_WIDTH:   width_ff   <= pwdata[X_W-1:0];
            REG_DEST_HEIGHT:  height_ff  <= pwdata[Y_W-1:0];
            REG_SRC_X_OFFSET: x_off_ff   <= pwdata[X_W-1:0];
            REG_SRC_Y_OFFSET: y_off_ff   <= pwdata[Y_W-1:0];
            default: ;
         endcase
      end
      view_ff <= view_in;
   end

   always_comb begin
      unique case (reg_idx)
         REG_PACK_FORMAT:  prdata = CSR_DATA_W'(fmt_raw_ff);
         REG_X_STEP:       prdata = CSR_DATA_W'(x_step_ff);
         REG_Y_STEP:       prdata = CSR_DATA_W'(y_step_ff);
         REG_DEST_WIDTH:   prdata = CSR_DATA_W'(width_ff);
         REG_DEST_HEIGHT:  prdata = CSR_DATA_W'(height_ff);
         REG_SRC_X_OFFSET: prdata = CSR_DATA_W'(x_off_ff);
         REG_SRC_Y_OFFSET: prdata = CSR_DATA_W'(y_off_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      w1      = (width_ff == '0) ? X_W'(1) : width_ff;
      h1      = (height_ff == '0) ? Y_W'(1) : height_ff;
      w_sum   = {1'b0, w1} + (X_W + 1)'(3);
      h_sum4  = {1'b0, h1} + (Y_W + 1)'(3);
      h_sum8  = {1'b0, h1} + (Y_W + 1)'(7);
      per_row = w_sum[X_W:2];
      rows4   = h_sum4[Y_W:2];
      rows8   = h_sum8[Y_W:3];

      view_in.width  = w1;
      view_in.height = h1;
      view_in.x_step = x_step_ff;
      view_in.y_step = y_step_ff;
      view_in.x_off  = x_off_ff;
      view_in.y_off  = y_off_ff;

      if (fmt_raw_ff == FMT_PLANES) begin
         view_in.fmt = FMT_PLANES;
      end else if (fmt_raw_ff == FMT_VERT) begin
         view_in.fmt = FMT_VERT;
      end else begin
         view_in.fmt = FMT_HORIZ;
      end

      unique case (view_in.fmt)
         FMT_VERT: begin
            total_raw       = TOTAL_W'(rows4) * TOTAL_W'(w1);
            view_in.divisor = w1;
         end
         FMT_PLANES: begin
            total_raw       = TOTAL_W'(rows8) * TOTAL_W'(w1);
            view_in.divisor = w1;
         end
         default: begin
            total_raw       = TOTAL_W'(h1) * TOTAL_W'(per_row);
            view_in.divisor = X_W'(per_row);
         end
      endcase

      view_in.total = (total_raw > TOTAL_W'(FRAME_CAP)) ? TOTAL_W'(FRAME_CAP) : total_raw;
   end

   assign cfg = view_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sfp_engine.sv =====
// Word sequencer: position tracking, divider, sample address pipeline and packing.
`default_nettype none

module sfp_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  sfp_pkg::req_word_type       req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sfp_pkg::rsp_word_type       rsp_word,
   input  sfp_pkg::cfg_view_type       cfg,
   input  logic                        cfg_write,
   output sfp_pkg::ram_req_type        ram_req,
   input  logic [sfp_pkg::PIX_W-1:0]   ram_rdata
);

   import sfp_pkg::*;

   localparam int QUO_W   = Y_W;
   localparam int REM_W   = X_W;
   localparam int COORD_W = Y_W + 3;
   localparam int PX_W    = X_W + STEP_W;
   localparam int PY_W    = Y_W + STEP_W;
   localparam int CNT_W   = $clog2(POS_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic               dirty_ff, dirty_in;
   logic [POS_W-1:0]   div_num_ff, div_num_in;
   logic [REM_W-1:0]   div_rem_ff, div_rem_in;
   logic [POS_W-1:0]   div_quo_ff, div_quo_in;
   logic [CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [DATA_W-1:0]  acc_data_ff, acc_data_in;
   logic [DATA_W-1:0]  acc_mask_ff, acc_mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic               s0_live_ff, s0_live_in;
   logic [SLOT_W-1:0]  s0_slot_ff;
   logic               s0_ok_ff, s0_ok_in;
   logic [X_W-1:0]     s0_x_ff, s0_x_in;
   logic [Y_W-1:0]     s0_y_ff, s0_y_in;
   logic               s1_live_ff;
   logic [SLOT_W-1:0]  s1_slot_ff;
   logic               s1_ok_ff;
   logic [PX_W-1:0]    s1_px_ff, s1_px_in;
   logic [PY_W-1:0]    s1_py_ff, s1_py_in;
   logic               s2_live_ff;
   logic [SLOT_W-1:0]  s2_slot_ff;
   logic               s2_ok_ff;
   logic [LIN_W-1:0]   s2_lin_ff, s2_lin_in;
   logic               s3_live_ff;
   logic [SLOT_W-1:0]  s3_slot_ff;
   logic               s3_ok_ff;

   logic [REM_W:0]     trial;
   logic [REM_W:0]     trial_sub;
   logic               trial_ge;
   logic [REM_W-1:0]   div_rem_step;
   logic [POS_W:0]     div_quo_full;
   logic [COORD_W-1:0] x_wide;
   logic [COORD_W-1:0] y_wide;
   logic [SLOT_W-1:0]  last_slot;
   logic [ROW_W-1:0]   row;
   logic [COL_W-1:0]   col;
   logic [3:0]         shift;
   logic [DATA_W-1:0]  pix16;
   logic [DATA_W-1:0]  planes16;
   logic [TOTAL_W-1:0] pos_inc;
   logic [REM_W:0]     rem_inc;
   logic               out_free;
   logic               write_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         quo_ff       <= '0;
         rem_ff       <= '0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s0_live_ff   <= 1'b0;
         s1_live_ff   <= 1'b0;
         s2_live_ff   <= 1'b0;
         s3_live_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         quo_ff       <= quo_in;
         rem_ff       <= rem_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         s0_live_ff   <= s0_live_in;
         s1_live_ff   <= s0_live_ff;
         s2_live_ff   <= s1_live_ff;
         s3_live_ff   <= s2_live_ff;
      end
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_cnt_ff  <= div_cnt_in;
      slot_ff     <= slot_in;
      acc_data_ff <= acc_data_in;
      acc_mask_ff <= acc_mask_in;
      rsp_word_ff <= rsp_word_in;
      s0_slot_ff  <= slot_ff;
      s0_ok_ff    <= s0_ok_in;
      s0_x_ff     <= s0_x_in;
      s0_y_ff     <= s0_y_in;
      s1_slot_ff  <= s0_slot_ff;
      s1_ok_ff    <= s0_ok_ff;
      s1_px_ff    <= s1_px_in;
      s1_py_ff    <= s1_py_in;
      s2_slot_ff  <= s1_slot_ff;
      s2_ok_ff    <= s1_ok_ff;
      s2_lin_ff   <= s2_lin_in;
      s3_slot_ff  <= s2_slot_ff;
      s3_ok_ff    <= s2_ok_ff;
   end

   // Restoring division step, one quotient bit a cycle.
   always_comb begin
      trial        = {div_rem_ff, div_num_ff[POS_W-1]};
      trial_sub    = trial - {1'b0, cfg.divisor};
      trial_ge     = trial >= {1'b0, cfg.divisor};
      div_rem_step = trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
      div_quo_full = {div_quo_ff, trial_ge};
   end

   // Destination coordinates of the slot being issued.
   always_comb begin
      last_slot = (cfg.fmt == FMT_PLANES) ? LAST_SLOT_PLANES : LAST_SLOT_BYTE;
      unique case (cfg.fmt)
         FMT_VERT: begin
            x_wide   = COORD_W'(rem_ff);
            y_wide   = COORD_W'({quo_ff, 2'b00}) + COORD_W'(slot_ff);
            s0_ok_in = y_wide < COORD_W'(cfg.height);
         end
         FMT_PLANES: begin
            x_wide   = COORD_W'(rem_ff);
            y_wide   = COORD_W'({quo_ff, 3'b000}) + COORD_W'(slot_ff);
            s0_ok_in = y_wide < COORD_W'(cfg.height);
         end
         default: begin
            x_wide   = COORD_W'({rem_ff, 2'b00}) + COORD_W'(slot_ff);
            y_wide   = COORD_W'(quo_ff);
            s0_ok_in = x_wide < COORD_W'(cfg.width);
         end
      endcase
      s0_x_in = x_wide[X_W-1:0];
      s0_y_in = y_wide[Y_W-1:0];
   end

   // Sample address pipeline.
   always_comb begin
      s1_px_in  = s0_x_ff * cfg.x_step;
      s1_py_in  = s0_y_ff * cfg.y_step;
      row       = ROW_W'(cfg.y_off) + ROW_W'(s1_py_ff[PY_W-1:FRAC_W]);
      col       = COL_W'(cfg.x_off) + COL_W'(s1_px_ff[PX_W-1:FRAC_W]);
      s2_lin_in = LIN_W'(row * SRC_WIDTH) + LIN_W'(col);
   end

   always_comb begin
      write_now     = (state_ff == ST_IDLE) && req_valid && (req_word.func == FUNC_WRITE);
      ram_req.we    = write_now;
      ram_req.wdata = req_word.pixel_value;
      ram_req.addr  = write_now ? src_reduce(RED_W'(req_word.pixel_address))
                                : src_reduce(RED_W'(s2_lin_ff));
   end

   always_comb begin
      pix16    = DATA_W'(ram_rdata);
      planes16 = DATA_W'({ram_rdata[1], 7'b0000000, ram_rdata[0]});
      pos_inc  = TOTAL_W'(pos_ff) + TOTAL_W'(1);
      rem_inc  = {1'b0, rem_ff} + (REM_W + 1)'(1);
      out_free = !rsp_valid_ff || !rsp_stall;

      state_in     = state_ff;
      pos_in       = pos_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dirty_in     = dirty_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_cnt_in   = div_cnt_ff;
      slot_in      = slot_ff;
      s0_live_in   = 1'b0;
      acc_data_in  = acc_data_ff;
      acc_mask_in  = acc_mask_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      shift        = 4'd0;

      if (s3_live_ff && s3_ok_ff) begin
         unique case (cfg.fmt)
            FMT_VERT: begin
               shift       = {1'b0, s3_slot_ff[1:0], 1'b0};
               acc_data_in = acc_data_ff | (pix16 << shift);
               acc_mask_in = acc_mask_ff | (DATA_W'(16'h0003) << shift);
            end
            FMT_PLANES: begin
               shift       = {1'b0, s3_slot_ff};
               acc_data_in = acc_data_ff | (planes16 << shift);
               acc_mask_in = acc_mask_ff | (DATA_W'(16'h0101) << shift);
            end
            default: begin
               shift       = {1'b0, ~s3_slot_ff[1:0], 1'b0};
               acc_data_in = acc_data_ff | (pix16 << shift);
               acc_mask_in = acc_mask_ff | (DATA_W'(16'h0003) << shift);
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_word.func == FUNC_EMIT) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            acc_data_in = '0;
            acc_mask_in = '0;
            slot_in     = '0;
            if (TOTAL_W'(pos_ff) >= cfg.total) begin
               pos_in   = '0;
               quo_in   = '0;
               rem_in   = '0;
               dirty_in = 1'b0;
               state_in = ST_RUN;
            end else if (dirty_ff) begin
               div_num_in = pos_ff;
               div_rem_in = '0;
               div_quo_in = '0;
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end else begin
               state_in = ST_RUN;
            end
         end
         ST_DIV: begin
            div_num_in = div_num_ff << 1;
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_full[POS_W-1:0];
            div_cnt_in = div_cnt_ff + CNT_W'(1);
            if (div_cnt_ff == CNT_W'(POS_W - 1)) begin
               quo_in   = div_quo_full[QUO_W-1:0];
               rem_in   = div_rem_step;
               dirty_in = 1'b0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            s0_live_in = 1'b1;
            slot_in    = slot_ff + SLOT_W'(1);
            if (slot_ff == last_slot) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s3_live_ff && s3_slot_ff == last_slot) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.word_address = pos_ff;
               rsp_word_in.word_data    = acc_data_ff;
               rsp_word_in.slot_mask    = acc_mask_ff;
               rsp_word_in.frame_last   = (pos_inc == cfg.total);
               if (pos_inc >= cfg.total) begin
                  pos_in = '0;
                  quo_in = '0;
                  rem_in = '0;
               end else begin
                  pos_in = pos_inc[POS_W-1:0];
                  if (rem_inc == (REM_W + 1)'(cfg.divisor)) begin
                     rem_in = '0;
                     quo_in = quo_ff + QUO_W'(1);
                  end else begin
                     rem_in = rem_inc[REM_W-1:0];
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_write) begin
         dirty_in = 1'b1;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/scaled_2bpp_framebuffer_packer.sv =====
// Scaled 2bpp frame buffer packer: source pixel store, word sequencer and register file.
// A pixel write word is taken while the sequencer is idle, and the next write can follow in the next cycle.
// An emit word steps the sequencer through its prepare, run, drain and done states, with the divider
// before the run state on the first emit after a register write; the result is registered once the
// response output is free, and the next word is taken when the sequencer is back in idle.
// Each emit word makes four or eight reads of the single-port store; reset leaves the store as it is.
`default_nettype none

module scaled_2bpp_framebuffer_packer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sfp_pkg::req_word_type            req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sfp_pkg::rsp_word_type            rsp_word,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sfp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [sfp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [sfp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   import sfp_pkg::*;

   cfg_view_type     cfg;
   logic             cfg_write;
   ram_req_type      ram_req;
   logic [PIX_W-1:0] ram_rdata;

   sfp_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .cfg       (cfg),
      .cfg_write (cfg_write)
   );

   sfp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .cfg       (cfg),
      .cfg_write (cfg_write),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   sfp_ram #(
      .WIDTH (PIX_W),
      .DEPTH (SRC_SIZE)
   ) u_pixels (
      .clock (clock),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire
